### rtl/rrts_pkg.sv
// Shared constants, codes and item types of the round-robin task scheduler.
package rrts_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int QREGS  = 4;
  localparam int QIDX_W = 2;
  localparam int Q_W    = 3;
  localparam int PID_W  = 16;

  // Item kinds.
  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_ADD    = 3'd1;
  localparam logic [2:0] KIND_REMOVE = 3'd2;
  localparam logic [2:0] KIND_YIELD  = 3'd3;
  localparam logic [2:0] KIND_REAP   = 3'd4;

  // Slot modes.
  localparam logic [1:0] MODE_READY   = 2'd0;
  localparam logic [1:0] MODE_RUNNING = 2'd1;
  localparam logic [1:0] MODE_ZOMBIE  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_NO_RUN    = 2'd3;

  // Reset values of the quantum registers.
  localparam logic [Q_W-1:0] Q_RESET0 = 3'd4;
  localparam logic [Q_W-1:0] Q_RESET1 = 3'd3;
  localparam logic [Q_W-1:0] Q_RESET2 = 3'd2;
  localparam logic [Q_W-1:0] Q_RESET3 = 3'd1;

  typedef struct packed {
    logic [2:0]       kind;
    logic [PID_W-1:0] task_id;
    logic [1:0]       priority_req;
  } req_t;

  typedef struct packed {
    logic [PID_W-1:0] running_id;
    logic             have_running;
    logic             switched;
    logic [1:0]       status;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic add2;
    logic rem;
    logic tick;
    logic reap;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go_add2;
    logic go_rem;
    logic go_tick;
    logic go_reap;
    logic walk_end;
  } sts_t;

endpackage

### rtl/rrts_ctrl.sv
// Controller state machine of the round-robin task scheduler.
module rrts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  rrts_pkg::sts_t sts,
  output rrts_pkg::cmd_t cmd
);
  import rrts_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ADD2 = 6'b000010,
    S_REM  = 6'b000100,
    S_TICK = 6'b001000,
    S_REAP = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   finish;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign finish    = (state == S_DONE) && (!rsp_valid || rsp_ready);

  // Commands follow the current state.
  always_comb begin
    cmd        = '0;
    cmd.accept = accept;
    cmd.add2   = (state == S_ADD2);
    cmd.rem    = (state == S_REM);
    cmd.tick   = (state == S_TICK);
    cmd.reap   = (state == S_REAP);
    cmd.finish = finish;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (sts.go_add2)      state_next = S_ADD2;
          else if (sts.go_rem)  state_next = S_REM;
          else if (sts.go_tick) state_next = S_TICK;
          else if (sts.go_reap) state_next = S_REAP;
          else                  state_next = S_DONE;
        end
      end
      S_ADD2, S_REM, S_TICK, S_REAP: begin
        if (sts.walk_end) state_next = S_DONE;
      end
      S_DONE: begin
        if (finish) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

endmodule

### rtl/rrts_datapath.sv
// Datapath of the round-robin task scheduler: slot tables, ring pointers and walker.
module rrts_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  rrts_pkg::req_t               req,
  input  logic                         cfg_we,
  input  logic [rrts_pkg::QIDX_W-1:0]  cfg_index,
  input  logic [rrts_pkg::Q_W-1:0]     cfg_data,
  input  rrts_pkg::cmd_t               cmd,
  output rrts_pkg::sts_t               sts,
  output rrts_pkg::rsp_t               rsp
);
  import rrts_pkg::*;

  // Slot tables.
  logic [SLOT_W-1:0] link_next [SLOTS];
  logic [PID_W-1:0]  slot_pid  [SLOTS];
  logic [1:0]        slot_prio [SLOTS];
  logic [1:0]        slot_mode [SLOTS];
  logic [SLOTS-1:0]  slot_used;

  // Ring and scheduling state.
  logic [SLOT_W-1:0] ring_head, ring_tail, running_slot;
  logic              ring_empty;
  logic [Q_W-1:0]    quantum_left;
  logic [CNT_W-1:0]  task_count;
  logic [PID_W-1:0]  running_pid;
  logic [Q_W-1:0]    quantum [QREGS];

  // Walker and latched item.
  logic [SLOT_W-1:0] cur, prev, new_slot;
  logic [CNT_W-1:0]  cnt;
  logic [PID_W-1:0]  pid_r;
  logic [1:0]        status_r;
  logic              sw_r;

  logic [SLOT_W-1:0] link_cur;
  logic [PID_W-1:0]  pid_cur;
  logic [1:0]        prio_cur;
  logic [1:0]        mode_cur;
  logic [SLOT_W-1:0] free_slot;
  logic              full;
  logic [Q_W-1:0]    q_dec;
  logic              pid_match;
  logic              reap_gone;

  assign link_cur  = link_next[cur];
  assign pid_cur   = slot_pid[cur];
  assign prio_cur  = slot_prio[cur];
  assign mode_cur  = slot_mode[cur];
  assign full      = (task_count >= CNT_W'(SLOTS));
  assign q_dec     = (quantum_left != '0) ? quantum_left - 1'b1 : '0;
  assign pid_match = (pid_cur == pid_r);
  assign reap_gone = (mode_cur == MODE_ZOMBIE) && (cur != running_slot);

  // Lowest free slot.
  always_comb begin
    free_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_used[i]) free_slot = SLOT_W'(i);
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.go_add2  = (req.kind == KIND_ADD) && !full && !ring_empty;
    sts.go_rem   = (req.kind == KIND_REMOVE) && !ring_empty;
    sts.go_tick  = (req.kind == KIND_TICK) && !ring_empty && (q_dec == '0);
    sts.go_reap  = (req.kind == KIND_REAP) && !ring_empty;
    sts.walk_end = cmd.add2
                || (cmd.rem && (pid_match || link_cur == ring_head))
                || (cmd.tick && cnt != '0 && (mode_cur != MODE_ZOMBIE || cnt > task_count))
                || (cmd.reap && cnt != '0 && cur == ring_head);
  end

  // Slot tables, written without reset.
  always_ff @(posedge clk) begin
    if (cmd.accept && req.kind == KIND_ADD && !full) begin
      slot_pid[free_slot]  <= req.task_id;
      slot_prio[free_slot] <= req.priority_req;
      if (ring_empty) begin
        link_next[free_slot] <= free_slot;
        slot_mode[free_slot] <= MODE_RUNNING;
      end else begin
        link_next[ring_tail] <= free_slot;
        slot_mode[free_slot] <= MODE_READY;
      end
    end
    if (cmd.add2) link_next[new_slot] <= ring_head;
    if (cmd.rem && pid_match) slot_mode[cur] <= MODE_ZOMBIE;
    if (cmd.tick) begin
      if (cnt == '0) begin
        if (mode_cur == MODE_RUNNING) slot_mode[cur] <= MODE_READY;
      end else if (mode_cur != MODE_ZOMBIE) begin
        slot_mode[cur] <= MODE_RUNNING;
      end
    end
    if (cmd.reap && cnt != '0 && cur != ring_head && reap_gone) link_next[prev] <= link_cur;
  end

  // Walker and item registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pid_r    <= req.task_id;
      new_slot <= free_slot;
      cur      <= (req.kind == KIND_TICK) ? running_slot : ring_head;
      cnt      <= '0;
    end
    if (cmd.rem && !pid_match) cur <= link_cur;
    if (cmd.tick) begin
      if (cnt == '0) begin
        cur <= link_cur;
        cnt <= CNT_W'(1);
      end else if (mode_cur == MODE_ZOMBIE && cnt <= task_count) begin
        cur <= link_cur;
        cnt <= cnt + 1'b1;
      end
    end
    if (cmd.reap) begin
      if (cnt == '0) begin
        prev <= cur;
        cur  <= link_cur;
        cnt  <= CNT_W'(1);
      end else if (cur != ring_head) begin
        if (!reap_gone) prev <= cur;
        cur <= link_cur;
      end
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used    <= '0;
      ring_head    <= '0;
      ring_tail    <= '0;
      running_slot <= '0;
      ring_empty   <= 1'b1;
      quantum_left <= '0;
      task_count   <= '0;
      running_pid  <= '0;
      status_r     <= ST_OK;
      sw_r         <= 1'b0;
      quantum[0]   <= Q_RESET0;
      quantum[1]   <= Q_RESET1;
      quantum[2]   <= Q_RESET2;
      quantum[3]   <= Q_RESET3;
    end else begin
      if (cfg_we) quantum[cfg_index] <= cfg_data;

      // Work done in the cycle an item is taken.
      if (cmd.accept) begin
        status_r <= ST_OK;
        sw_r     <= 1'b0;
        case (req.kind)
          KIND_TICK: begin
            if (ring_empty) status_r <= ST_NO_RUN;
            else quantum_left <= q_dec;
          end
          KIND_ADD: begin
            if (full) begin
              status_r <= ST_FULL;
            end else begin
              slot_used[free_slot] <= 1'b1;
              task_count           <= task_count + 1'b1;
              if (ring_empty) begin
                ring_empty   <= 1'b0;
                ring_head    <= free_slot;
                ring_tail    <= free_slot;
                running_slot <= free_slot;
                running_pid  <= req.task_id;
                quantum_left <= quantum[req.priority_req];
              end
            end
          end
          KIND_REMOVE: begin
            if (ring_empty) status_r <= ST_NOT_FOUND;
          end
          KIND_YIELD: begin
            if (ring_empty) status_r <= ST_NO_RUN;
            else quantum_left <= '0;
          end
          default: ;
        endcase
      end

      if (cmd.add2) ring_tail <= new_slot;

      if (cmd.rem && !pid_match && link_cur == ring_head) status_r <= ST_NOT_FOUND;

      // Switch to the first task that is not a zombie.
      if (cmd.tick && cnt != '0) begin
        if (mode_cur != MODE_ZOMBIE) begin
          running_slot <= cur;
          running_pid  <= pid_cur;
          quantum_left <= quantum[prio_cur];
          sw_r         <= 1'b1;
        end else if (cnt > task_count) begin
          status_r <= ST_NO_RUN;
        end
      end

      // Unlink a zombie that is not running.
      if (cmd.reap && cnt != '0 && cur != ring_head && reap_gone) begin
        slot_used[cur] <= 1'b0;
        task_count     <= task_count - 1'b1;
        if (cur == ring_tail) ring_tail <= prev;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.running_id   <= ring_empty ? '0 : running_pid;
      rsp.have_running <= !ring_empty;
      rsp.switched     <= sw_r;
      rsp.status       <= status_r;
    end
  end

endmodule

### rtl/round_robin_task_scheduler_top.sv
// Top level of the round-robin task scheduler.
// The scheduler takes one item at a time and returns one result per item. Yield,
// an unknown kind, a plain tick, an add to a full table and any item on an empty
// ring go straight from accept to DONE and the result; any other add first passes
// ADD2, which links the new slot in at the tail. Remove, a tick that ends the
// quantum and reap walk the ring one slot a cycle through the single link table
// read port. A new item is taken while an earlier result still waits in the output
// register.
module round_robin_task_scheduler_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  rrts_pkg::req_t               req,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output rrts_pkg::rsp_t               rsp,
  input  logic                         cfg_we,
  input  logic [rrts_pkg::QIDX_W-1:0]  cfg_index,
  input  logic [rrts_pkg::Q_W-1:0]     cfg_data
);
  import rrts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rrts_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp)
  );

endmodule

### rtl/rrts_checker.sv
// Port-level checks of the round-robin task scheduler and their binding.
module rrts_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input rrts_pkg::rsp_t rsp,
  input logic           rsp_valid,
  input logic           rsp_ready
);
  import rrts_pkg::*;

  // A stalled result keeps its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // With no running task the pid reads zero and nothing switched.
  a_idle_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.have_running |-> rsp.running_id == '0 && !rsp.switched)
    else $error("result without running task is not clean");

  // A switch always leaves a running task and an ok status.
  a_switch_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.switched |-> rsp.have_running && rsp.status == ST_OK)
    else $error("switch with bad status");

  // An item taken gives no new result in the very next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !rsp_valid |=> !rsp_valid)
    else $error("result appeared too early");

endmodule

bind round_robin_task_scheduler_top rrts_checker u_rrts_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp       (rsp),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready)
);

### sim/tb_top.sv
// Self-checking testbench for the round-robin task scheduler, with a behavioral scheduler model.
`timescale 1ns / 100ps

module tb_top;
  import rrts_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_ready;
  req_t                req = '0;
  logic                rsp_valid;
  logic                rsp_ready = 1'b0;
  rsp_t                rsp;
  logic                cfg_we = 1'b0;
  logic [QIDX_W-1:0]   cfg_index = '0;
  logic [Q_W-1:0]      cfg_data = '0;

  round_robin_task_scheduler_top uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int REAP_BUDGET = 100;
  localparam int SETTLE = 40;
  localparam int STALL_LIMIT = 5000;

  // Shadow scheduler state.
  logic [SLOT_W-1:0] nxt_link [SLOTS];
  logic [PID_W-1:0]  tsk_pid  [SLOTS];
  logic [1:0]        tsk_prio [SLOTS];
  logic [1:0]        tsk_mode [SLOTS];
  logic              tsk_used [SLOTS];
  logic [SLOT_W-1:0] head, tail, cur_run;
  logic              empty_ring;
  logic [Q_W-1:0]    ticks_left;
  int                n_tasks;
  logic [Q_W-1:0]    grant_reg [QREGS];

  req_t pending_items [$];
  rsp_t expected_rsp [$];
  int   send_idle = 0, recv_stall = 0;
  int   errors = 0, n_rsp = 0, n_switch = 0, n_full = 0, n_norun = 0, quiet = 0;

  // Computes the result of one item and advances the shadow state.
  function automatic rsp_t schedule_item(req_t r);
    rsp_t o;
    logic [1:0] st;
    logic sw;
    logic [SLOT_W-1:0] nx, cur, prv, gone;
    int chk, s, budget;
    st = ST_OK;
    sw = 1'b0;
    case (r.kind)
      KIND_TICK: begin
        if (empty_ring) st = ST_NO_RUN;
        else begin
          if (ticks_left > 0) ticks_left--;
          if (ticks_left == 0) begin
            if (tsk_mode[cur_run] == MODE_RUNNING) tsk_mode[cur_run] = MODE_READY;
            nx = nxt_link[cur_run];
            chk = 0;
            while (tsk_mode[nx] == MODE_ZOMBIE && chk < n_tasks) begin
              nx = nxt_link[nx];
              chk++;
            end
            if (tsk_mode[nx] == MODE_ZOMBIE) st = ST_NO_RUN;
            else begin
              cur_run = nx;
              tsk_mode[nx] = MODE_RUNNING;
              ticks_left = grant_reg[tsk_prio[nx]];
              sw = 1'b1;
            end
          end
        end
      end
      KIND_ADD: begin
        if (n_tasks >= SLOTS) st = ST_FULL;
        else begin
          for (s = 0; s < SLOTS; s++) if (!tsk_used[s]) break;
          tsk_used[s] = 1'b1;
          tsk_pid[s] = r.task_id;
          tsk_prio[s] = r.priority_req;
          n_tasks++;
          if (empty_ring) begin
            empty_ring = 1'b0;
            head = SLOT_W'(s);
            tail = SLOT_W'(s);
            cur_run = SLOT_W'(s);
            nxt_link[s] = SLOT_W'(s);
            tsk_mode[s] = MODE_RUNNING;
            ticks_left = grant_reg[r.priority_req];
          end else begin
            nxt_link[tail] = SLOT_W'(s);
            nxt_link[s] = head;
            tail = SLOT_W'(s);
            tsk_mode[s] = MODE_READY;
          end
        end
      end
      KIND_REMOVE: begin
        st = ST_NOT_FOUND;
        if (!empty_ring) begin
          cur = head;
          for (int n = 0; n < n_tasks; n++) begin
            if (tsk_pid[cur] == r.task_id) begin
              tsk_mode[cur] = MODE_ZOMBIE;
              st = ST_OK;
              break;
            end
            cur = nxt_link[cur];
            if (cur == head) break;
          end
        end
      end
      KIND_YIELD: begin
        if (empty_ring) st = ST_NO_RUN;
        else ticks_left = '0;
      end
      KIND_REAP: begin
        if (!empty_ring) begin
          prv = head;
          cur = nxt_link[head];
          budget = REAP_BUDGET;
          while (cur != head && budget > 0) begin
            budget--;
            if (tsk_mode[cur] == MODE_ZOMBIE && cur != cur_run) begin
              gone = cur;
              nxt_link[prv] = nxt_link[gone];
              cur = nxt_link[prv];
              if (gone == tail) tail = prv;
              tsk_used[gone] = 1'b0;
              if (n_tasks > 0) n_tasks--;
            end else begin
              prv = cur;
              cur = nxt_link[cur];
            end
          end
        end
      end
      default: ;
    endcase
    o.running_id = empty_ring ? '0 : tsk_pid[cur_run];
    o.have_running = !empty_ring;
    o.switched = sw;
    o.status = st;
    return o;
  endfunction

  function automatic req_t mk_item(logic [2:0] k, logic [PID_W-1:0] p, logic [1:0] pr);
    req_t r;
    r.kind = k;
    r.task_id = p;
    r.priority_req = pr;
    return r;
  endfunction

  // Clock.
  initial begin
    forever #10 clk = ~clk;
  end

  // Driver: presents queued items, predicting each one as it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) expected_rsp.push_back(schedule_item(req));
      if (!req_valid || req_ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
          req <= pending_items.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          $error("result with no item pending: %p", rsp);
          errors++;
        end else begin
          rsp_t e;
          e = expected_rsp.pop_front();
          n_rsp++;
          if (e.switched) n_switch++;
          if (e.status == ST_FULL) n_full++;
          if (e.status == ST_NO_RUN) n_norun++;
          if (rsp.running_id !== e.running_id) begin
            $error("running_id expected %0d actual %0d", e.running_id, rsp.running_id);
            errors++;
          end
          if (rsp.have_running !== e.have_running) begin
            $error("have_running expected %0d actual %0d", e.have_running, rsp.have_running);
            errors++;
          end
          if (rsp.switched !== e.switched) begin
            $error("switched expected %0d actual %0d", e.switched, rsp.switched);
            errors++;
          end
          if (rsp.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, rsp.status);
            errors++;
          end
        end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Watchdog on cycles without any accepted item, accepted result or configuration write.
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_we) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("round_robin_task_scheduler_top regression: fail");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || req_valid || expected_rsp.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_quanta(logic [Q_W-1:0] q0, logic [Q_W-1:0] q1,
                             logic [Q_W-1:0] q2, logic [Q_W-1:0] q3);
    logic [Q_W-1:0] v [QREGS];
    v = '{q0, q1, q2, q3};
    for (int i = 0; i < QREGS; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= i[QIDX_W-1:0];
      cfg_data <= v[i];
      grant_reg[i] = v[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random mix: adds and ticks dominate, pids mostly from a small pool.
  task automatic queue_random(int count);
    logic [PID_W-1:0] p;
    int w;
    for (int i = 0; i < count; i++) begin
      w = $urandom_range(99);
      p = ($urandom_range(9) < 7) ? PID_W'($urandom_range(31)) : PID_W'($urandom);
      if (w < 25) pending_items.push_back(mk_item(KIND_ADD, p, 2'($urandom)));
      else if (w < 60) pending_items.push_back(mk_item(KIND_TICK, PID_W'($urandom), 2'($urandom)));
      else if (w < 72) pending_items.push_back(mk_item(KIND_REMOVE, p, 2'($urandom)));
      else if (w < 82) pending_items.push_back(mk_item(KIND_YIELD, p, 2'($urandom)));
      else if (w < 94) pending_items.push_back(mk_item(KIND_REAP, p, 2'($urandom)));
      else pending_items.push_back(mk_item(3'($urandom_range(7, 5)), PID_W'($urandom),
                                           2'($urandom)));
    end
  endtask

  // Stimulus sequence and final verdict.
  initial begin
    for (int i = 0; i < SLOTS; i++) tsk_used[i] = 1'b0;
    head = '0; tail = '0; cur_run = '0; empty_ring = 1'b1; ticks_left = '0; n_tasks = 0;
    grant_reg = '{Q_RESET0, Q_RESET1, Q_RESET2, Q_RESET3};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    load_quanta(Q_RESET0, Q_RESET1, Q_RESET2, Q_RESET3);

    // Directed: empty ring cases, unknown kinds, extremes, full table, zombie running task.
    pending_items.push_back(mk_item(KIND_TICK, '0, 2'd0));
    pending_items.push_back(mk_item(KIND_YIELD, '0, 2'd0));
    pending_items.push_back(mk_item(KIND_REMOVE, 16'hFFFF, 2'd0));
    pending_items.push_back(mk_item(KIND_REAP, '0, 2'd0));
    pending_items.push_back(mk_item(3'd5, 16'hFFFF, 2'd3));
    pending_items.push_back(mk_item(3'd7, '0, 2'd0));
    pending_items.push_back(mk_item(KIND_ADD, 16'hFFFF, 2'd3));
    pending_items.push_back(mk_item(KIND_ADD, '0, 2'd0));
    for (int i = 2; i < SLOTS; i++)
      pending_items.push_back(mk_item(KIND_ADD, PID_W'(i), 2'(i)));
    pending_items.push_back(mk_item(KIND_ADD, 16'h1234, 2'd1));
    pending_items.push_back(mk_item(KIND_REMOVE, 16'h7777, 2'd0));
    pending_items.push_back(mk_item(KIND_REMOVE, 16'hFFFF, 2'd0));
    pending_items.push_back(mk_item(KIND_REMOVE, '0, 2'd0));
    pending_items.push_back(mk_item(KIND_REAP, '0, 2'd0));
    pending_items.push_back(mk_item(KIND_TICK, '0, 2'd0));
    pending_items.push_back(mk_item(KIND_YIELD, '0, 2'd0));
    pending_items.push_back(mk_item(KIND_TICK, '0, 2'd0));
    pending_items.push_back(mk_item(KIND_REAP, '0, 2'd0));
    wait_drained();

    // Phases of random traffic under different idling and quantum settings.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  load_quanta(3'd7, 3'd7, 3'd7, 3'd7); end
        1: begin send_idle = 47; recv_stall = 0;  load_quanta(3'd1, 3'd1, 3'd1, 3'd1); end
        2: begin send_idle = 0;  recv_stall = 47; load_quanta(3'd0, 3'd5, 3'd2, 3'd7); end
        default: begin
          send_idle = 8; recv_stall = 8;
          load_quanta(3'($urandom), 3'($urandom), 3'($urandom), 3'($urandom));
        end
      endcase
      queue_random(215);
      wait_drained();
    end

    $display("Checked %0d results: %0d task switches, %0d full-table adds, %0d no-runnable.",
             n_rsp, n_switch, n_full, n_norun);
    $display("Four idling phases ran under five quantum settings, zero quanta included.");
    if (errors == 0) begin
      $display("round_robin_task_scheduler_top regression: pass");
    end else begin
      $display("round_robin_task_scheduler_top regression: fail");
    end
    $finish;
  end

endmodule

### round_robin_task_scheduler_top.f
rtl/rrts_pkg.sv
rtl/rrts_ctrl.sv
rtl/rrts_datapath.sv
rtl/round_robin_task_scheduler_top.sv
rtl/rrts_checker.sv
sim/tb_top.sv
